### hw/rtl/stt_pkg.sv
// Types and codes shared by the software timer table.
`default_nettype none

package stt_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_BIND  = 3'd2,
    OP_SET   = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_FAIL  = 2'd1,
    KIND_FIRE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_FREE  = 2'd0,
    STATUS_ALLOC = 2'd1,
    STATUS_ARMED = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  timer_index;
    logic [3:0]  queue_id;
    logic [7:0]  payload;
    logic [31:0] delay_ticks;
  } in_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] entry;
    logic [3:0] dest_queue;
    logic [7:0] fire_data;
    logic       last;
  } out_rsp_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] deadline;
    logic [3:0]  queue;
    logic [7:0]  data;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

endpackage

`default_nettype wire

### hw/rtl/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/software_timer_table_unit.sv
// Top level of the software timer table: request sequencer around the entry RAM.
// Free, bind and set read the entry, then write it back; no response.
// Allocate scans from entry 0, one entry per cycle: grant for the first free
// entry, failure after the last one. Tick scans all entries, one per cycle
// while the response side does not back up, and stalls when it does.
// Reset clears the tick count and the per-entry valid bits (an invalid entry
// reads as free); the RAM itself is not cleared, so no clearing pass is needed.
`default_nettype none

module software_timer_table_unit #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire stt_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output stt_pkg::out_rsp_t      out_rsp_o
);
  import stt_pkg::*;

  localparam int unsigned TABLE_SIZE = (NUM_TIMERS < 32) ? NUM_TIMERS : 32;
  localparam int unsigned IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RMW   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  localparam entry_t EntryReset = '{status: STATUS_FREE, deadline: '0, queue: '0, data: '0};

  logic [1:0]            state_q, state_d;
  logic [2:0]            op_q;
  logic [IDX_W-1:0]      cur_q, cur_d;
  logic [3:0]            queue_q;
  logic [7:0]            data_q;
  logic [31:0]           delay_q;
  logic [31:0]           count_q, count_d;
  logic [TABLE_SIZE-1:0] valid_q;
  logic                  pend_valid_q, pend_valid_d;
  out_rsp_t              pend_q, pend_d;
  logic                  out_valid_q;
  out_rsp_t              out_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  ram_re, ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [EntryWidth-1:0] ram_rdata;
  entry_t                ent, ram_wdata;
  logic                  push;
  out_rsp_t              push_rsp;
  logic                  last_ent;
  logic                  hit_free, hit_fire;

  stt_ram #(
    .WIDTH(EntryWidth),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cur_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign ent      = valid_q[cur_q] ? entry_t'(ram_rdata) : EntryReset;
  assign last_ent = (cur_q == IDX_W'(TABLE_SIZE - 1));
  assign hit_free = (ent.status == STATUS_FREE);
  assign hit_fire = (ent.status == STATUS_ARMED) && (ent.deadline <= count_q);

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    count_d      = count_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    ram_re       = 1'b0;
    ram_raddr    = cur_q;
    ram_we       = 1'b0;
    ram_wdata    = ent;
    push         = 1'b0;
    push_rsp     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_i.op)
            OP_ALLOC, OP_TICK: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              cur_d     = '0;
              state_d   = S_SCAN;
              if (in_req_i.op == OP_TICK) begin
                count_d = count_q + 32'd1;
              end
            end
            OP_FREE, OP_BIND, OP_SET: begin
              if ({1'b0, in_req_i.timer_index} < 6'(TABLE_SIZE)) begin
                ram_re    = 1'b1;
                ram_raddr = in_req_i.timer_index[IDX_W-1:0];
                cur_d     = in_req_i.timer_index[IDX_W-1:0];
                state_d   = S_RMW;
              end
            end
            default: ;
          endcase
        end
      end
      S_RMW: begin
        ram_we  = 1'b1;
        state_d = S_IDLE;
        case (op_q)
          OP_FREE: ram_wdata.status = STATUS_FREE;
          OP_BIND: begin
            ram_wdata.queue = queue_q;
            ram_wdata.data  = data_q;
          end
          OP_SET: begin
            ram_wdata.deadline = delay_q + count_q;
            ram_wdata.status   = STATUS_ARMED;
          end
          default: ram_we = 1'b0;
        endcase
      end
      S_SCAN: begin
        if (op_q == OP_ALLOC) begin
          if (hit_free) begin
            if (out_free) begin
              ram_we           = 1'b1;
              ram_wdata.status = STATUS_ALLOC;
              push             = 1'b1;
              push_rsp         = '{kind: KIND_GRANT, entry: 5'(cur_q), dest_queue: '0,
                                   fire_data: '0, last: 1'b1};
              state_d          = S_IDLE;
            end
          end else if (last_ent) begin
            if (out_free) begin
              push     = 1'b1;
              push_rsp = '{kind: KIND_FAIL, entry: '0, dest_queue: '0,
                           fire_data: '0, last: 1'b1};
              state_d  = S_IDLE;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cur_q + 1'b1;
            cur_d     = cur_q + 1'b1;
          end
        end else if (!(hit_fire && pend_valid_q && !out_free)) begin
          if (hit_fire) begin
            ram_we           = 1'b1;
            ram_wdata.status = STATUS_ALLOC;
            pend_valid_d     = 1'b1;
            pend_d           = '{kind: KIND_FIRE, entry: 5'(cur_q), dest_queue: ent.queue,
                                 fire_data: ent.data, last: 1'b0};
            if (pend_valid_q) begin
              push     = 1'b1;
              push_rsp = pend_q;
            end
          end
          if (last_ent) begin
            state_d = S_FLUSH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cur_q + 1'b1;
            cur_d     = cur_q + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          push          = 1'b1;
          push_rsp      = pend_q;
          push_rsp.last = 1'b1;
          pend_valid_d  = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      valid_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cur_q        <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      cur_q        <= cur_d;
      if (ram_we) begin
        valid_q[cur_q] <= 1'b1;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (push) begin
      out_q <= push_rsp;
    end
    if (in_acc) begin
      op_q    <= in_req_i.op;
      queue_q <= in_req_i.queue_id;
      data_q  <= in_req_i.payload;
      delay_q <= in_req_i.delay_ticks;
    end
  end

endmodule

`default_nettype wire

### test/tb_software_timer_table_unit.sv
// Testbench for software_timer_table_unit: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module tb_software_timer_table_unit;
  import stt_pkg::*;

  localparam int TableSize = 32;
  localparam int CycleLimit = 1_000_000;
  localparam int TailCycles = 100;
  localparam logic [2:0] OpUnusedFirst = 3'd5;
  localparam logic [2:0] OpUnusedLast = 3'd7;

  typedef struct packed {
    logic [31:0]                  count;
    logic [TableSize-1:0][1:0]    status;
    logic [TableSize-1:0][31:0]   deadline;
    logic [TableSize-1:0][3:0]    queue;
    logic [TableSize-1:0][7:0]    data;
    logic [TableSize-1:0]         bound;
  } table_image_t;

  typedef struct packed {
    table_image_t                 next;
    out_rsp_t [TableSize-1:0]     rsp;
    logic [5:0]                   n;
  } table_step_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  in_req_t in_req = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_rsp_t out_rsp_o;

  in_req_t pending_reqs[$];
  out_rsp_t awaited_rsps[$];
  table_image_t plan_table = '0;
  table_image_t live_table = '0;
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 77;
  int planned = 0;
  int error_count = 0;
  int cycle_count = 0;

  software_timer_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o)
  );

  function automatic table_step_t advance_table(input table_image_t s, input in_req_t rq);
    table_step_t r;
    logic found;
    r = '0;
    r.next = s;
    found = 1'b0;
    case (rq.op)
      OP_ALLOC: begin
        for (int i = 0; i < TableSize; i++) begin
          if (!found && s.status[i] == STATUS_FREE) begin
            found = 1'b1;
            r.next.status[i] = STATUS_ALLOC;
            r.rsp[0].entry = 5'(i);
          end
        end
        r.rsp[0].kind = found ? KIND_GRANT : KIND_FAIL;
        r.rsp[0].last = 1'b1;
        r.n = 6'd1;
      end
      OP_FREE: r.next.status[rq.timer_index] = STATUS_FREE;
      OP_BIND: begin
        r.next.queue[rq.timer_index] = rq.queue_id;
        r.next.data[rq.timer_index] = rq.payload;
        r.next.bound[rq.timer_index] = 1'b1;
      end
      OP_SET: begin
        r.next.deadline[rq.timer_index] = rq.delay_ticks + s.count;
        r.next.status[rq.timer_index] = STATUS_ARMED;
      end
      OP_TICK: begin
        r.next.count = s.count + 32'd1;
        for (int i = 0; i < TableSize; i++) begin
          if (s.status[i] == STATUS_ARMED && s.deadline[i] <= r.next.count) begin
            r.next.status[i] = STATUS_ALLOC;
            r.rsp[r.n].kind = KIND_FIRE;
            r.rsp[r.n].entry = 5'(i);
            r.rsp[r.n].dest_queue = s.queue[i];
            r.rsp[r.n].fire_data = s.data[i];
            r.n = r.n + 6'd1;
          end
        end
        if (r.n != 0) r.rsp[r.n - 6'd1].last = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req <= '0;
    end else if (!in_valid || !in_stall_o) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_req <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // monitor: check responses, then predict from accepted requests
  always @(posedge clk_i) begin
    table_step_t st;
    out_rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (awaited_rsps.size() == 0) begin
          $display("%0t: unexpected response: expected none, got %h", $time, out_rsp_o);
          error_count++;
        end else begin
          want = awaited_rsps.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_rsp_o.kind));
          check_field("entry", 32'(want.entry), 32'(out_rsp_o.entry));
          check_field("dest_queue", 32'(want.dest_queue), 32'(out_rsp_o.dest_queue));
          check_field("fire_data", 32'(want.fire_data), 32'(out_rsp_o.fire_data));
          check_field("last", 32'(want.last), 32'(out_rsp_o.last));
        end
      end
      if (in_valid && !in_stall_o) begin
        st = advance_table(live_table, in_req);
        live_table = st.next;
        for (int k = 0; k < st.n; k++) awaited_rsps.push_back(st.rsp[k]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_req_t rand_req(input logic [2:0] op);
    in_req_t rq;
    rq.op = op;
    rq.timer_index = 5'($urandom);
    rq.queue_id = 4'($urandom);
    rq.payload = 8'($urandom);
    rq.delay_ticks = $urandom;
    return rq;
  endfunction

  function automatic in_req_t bind_req(input logic [4:0] idx, input logic [3:0] q,
                                       input logic [7:0] d);
    in_req_t rq;
    rq = rand_req(OP_BIND);
    rq.timer_index = idx;
    rq.queue_id = q;
    rq.payload = d;
    return rq;
  endfunction

  function automatic in_req_t set_req(input logic [4:0] idx, input logic [31:0] delay);
    in_req_t rq;
    rq = rand_req(OP_SET);
    rq.timer_index = idx;
    rq.delay_ticks = delay;
    return rq;
  endfunction

  function automatic in_req_t free_req(input logic [4:0] idx);
    in_req_t rq;
    rq = rand_req(OP_FREE);
    rq.timer_index = idx;
    return rq;
  endfunction

  function automatic logic [31:0] pick_delay();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(8);
    else if (roll < 75) return $urandom_range(60, 9);
    else if (roll < 85) return $urandom;
    else return 32'hFFFF_FFFF - $urandom_range(20);
  endfunction

  task automatic plan(input in_req_t rq, output table_step_t st);
    st = advance_table(plan_table, rq);
    plan_table = st.next;
    pending_reqs.push_back(rq);
    if (rq.op < OpUnusedFirst) planned++;
  endtask

  // entries are only armed once bound, so an expiry never carries unwritten data
  task automatic pick_bound(output logic ok, output logic [4:0] idx);
    logic [4:0] start;
    start = 5'($urandom);
    ok = 1'b0;
    idx = '0;
    for (int i = 0; i < TableSize; i++) begin
      if (!ok && plan_table.bound[5'(start + i)]) begin
        ok = 1'b1;
        idx = 5'(start + i);
      end
    end
  endtask

  task automatic plan_fill();
    table_step_t st;
    logic granted;
    logic [4:0] idx;
    do begin
      plan(rand_req(OP_ALLOC), st);
      granted = (st.rsp[0].kind == KIND_GRANT);
      idx = st.rsp[0].entry;
      if (granted) plan(bind_req(idx, 4'($urandom), 8'($urandom)), st);
    end while (granted);
  endtask

  task automatic plan_directed();
    table_step_t st;
    plan(rand_req(OP_TICK), st);
    plan(rand_req(OP_ALLOC), st);
    plan(rand_req(OP_ALLOC), st);
    plan(bind_req(5'd0, 4'hF, 8'hFF), st);
    plan(bind_req(5'd1, 4'h0, 8'h00), st);
    plan(set_req(5'd0, 32'h0), st);
    plan(set_req(5'd1, 32'hFFFF_FFFF), st);
    plan(rand_req(OP_TICK), st);
    // unallocated entry armed anyway
    plan(bind_req(5'd31, 4'h5, 8'hA5), st);
    plan(set_req(5'd31, 32'd2), st);
    // armed entry released before it fires
    plan(set_req(5'd1, 32'd1), st);
    plan(free_req(5'd1), st);
    plan(rand_req(OP_TICK), st);
    plan(rand_req(OP_TICK), st);
    plan(rand_req(OpUnusedFirst), st);
    plan(rand_req(OpUnusedLast), st);
    plan(set_req(5'd0, 32'h8000_0000), st);
    plan(rand_req(OP_TICK), st);
    plan(free_req(5'd0), st);
    plan(free_req(5'd31), st);
    plan(rand_req(OP_ALLOC), st);
  endtask

  task automatic plan_random(input int goal);
    table_step_t st;
    int start;
    int unsigned roll;
    logic ok;
    logic [4:0] idx;
    start = planned;
    while (planned - start < goal) begin
      roll = $urandom_range(99);
      if (roll < 28) begin
        plan(rand_req(OP_ALLOC), st);
        if (st.rsp[0].kind == KIND_GRANT) begin
          idx = st.rsp[0].entry;
          plan(bind_req(idx, 4'($urandom), 8'($urandom)), st);
          plan(set_req(idx, pick_delay()), st);
        end
      end else if (roll < 58) begin
        repeat ($urandom_range(3, 1)) plan(rand_req(OP_TICK), st);
      end else if (roll < 68) begin
        pick_bound(ok, idx);
        if (ok) plan(set_req(idx, pick_delay()), st);
      end else if (roll < 74) begin
        plan(rand_req(OP_BIND), st);
      end else if (roll < 90) begin
        plan(rand_req(OP_FREE), st);
      end else if (roll < 94) begin
        plan(rand_req(3'($urandom_range(OpUnusedLast, OpUnusedFirst))), st);
      end else if (roll < 97) begin
        // many entries due on the same tick
        for (int i = 0; i < TableSize; i++)
          if (plan_table.bound[i] && $urandom_range(1)) plan(set_req(5'(i), $urandom_range(2)), st);
        repeat (3) plan(rand_req(OP_TICK), st);
      end else begin
        plan_fill();
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid || awaited_rsps.size() != 0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    plan_directed();
    plan_fill();
    plan_random(105);
    // hold off new requests until every response is back
    wait_drained();
    send_idle_pct = 77;
    recv_idle_pct = 16;
    plan_random(105);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    plan_random(105);
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_ram.sv
hw/rtl/software_timer_table_unit.sv
test/tb_software_timer_table_unit.sv
